FILE: hw/rtl/cirsz_pkg.sv
// shared types, register indexes and default sizes of the cropped resize unit
package cirsz_pkg;

  localparam int DefMaxHeight   = 128;
  localparam int DefMaxWidth    = 128;
  localparam int DefMaxChannels = 4;
  localparam int DefPixelBits   = 16;

  localparam logic [2:0] RegMode      = 3'd0;
  localparam logic [2:0] RegSrcHeight = 3'd1;
  localparam logic [2:0] RegSrcWidth  = 3'd2;
  localparam logic [2:0] RegCropBegin = 3'd3;
  localparam logic [2:0] RegCropEnd   = 3'd4;
  localparam logic [2:0] RegDstHeight = 3'd5;
  localparam logic [2:0] RegDstWidth  = 3'd6;
  localparam logic [2:0] RegChanCount = 3'd7;

  localparam logic OpLoad    = 1'b0;
  localparam logic OpCompute = 1'b1;

  typedef struct packed {
    logic capture;
    logic div_load;
    logic sel_x;
    logic div_step;
    logic set_y;
    logic set_x;
    logic rd;
    logic mac;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic nb_last;
    logic bad;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/cropped_image_resize_bilinear_nearest_unit.sv
// Cropped image resize unit, nearest neighbour or bilinear with align-corners ratio.
// A load transaction (tuser 0) writes one source pixel into the internal store. A
// compute transaction (tuser 1) goes through these steps after acceptance: a setup state
// and a 24-step division on the shared one-bit-per-cycle divider for the row, then the
// same for the column, a state to form each position, four store reads with a
// multiply-accumulate each and a state to load the output register. The input is ready
// again the cycle after that load. A request that is out of range skips the divisions
// and has its result loaded with tuser set and pixel 0. The input is not taken while a
// compute is in flight; a finished result waits in the output register while the next
// transaction is accepted, and a compute stalls before its output load while that
// register is full. The pixel store has no reset.
module cropped_image_resize_bilinear_nearest_unit #(
  parameter int MAX_HEIGHT   = cirsz_pkg::DefMaxHeight,
  parameter int MAX_WIDTH    = cirsz_pkg::DefMaxWidth,
  parameter int MAX_CHANNELS = cirsz_pkg::DefMaxChannels,
  parameter int PIXEL_BITS   = cirsz_pkg::DefPixelBits
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [10:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // row, col, channel, pixel_in
  input  logic        s_axis_tuser,  // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,  // out_row, out_col, out_channel, pixel_out
  output logic        m_axis_tuser   // bad_request
);
  import cirsz_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        in_fire;
  logic [9:0]  o_row;
  logic [9:0]  o_col;
  logic [1:0]  o_ch;
  logic [15:0] o_pixel;

  assign cfg_ready = 1'b1;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  cirsz_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cirsz_dp #(
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS),
    .PIXEL_BITS   (PIXEL_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_fire     (in_fire),
    .in_op       (s_axis_tuser),
    .in_row      (s_axis_tdata[9:0]),
    .in_col      (s_axis_tdata[19:10]),
    .in_channel  (s_axis_tdata[21:20]),
    .in_pixel    (s_axis_tdata[37:22]),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_row     (o_row),
    .out_col     (o_col),
    .out_channel (o_ch),
    .out_pixel   (o_pixel),
    .out_bad     (m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, o_pixel, o_ch, o_col, o_row};

endmodule

FILE: hw/rtl/cirsz_ctrl.sv
// sequencer for load and compute transactions
module cirsz_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_op,
  output logic            in_ready,
  input  cirsz_pkg::sts_t sts,
  output cirsz_pkg::cmd_t cmd
);
  import cirsz_pkg::*;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SPrepY = 4'd1;
  localparam logic [3:0] SDivY  = 4'd2;
  localparam logic [3:0] SMulY  = 4'd3;
  localparam logic [3:0] SPrepX = 4'd4;
  localparam logic [3:0] SDivX  = 4'd5;
  localparam logic [3:0] SMulX  = 4'd6;
  localparam logic [3:0] SRead  = 4'd7;
  localparam logic [3:0] SMac   = 4'd8;
  localparam logic [3:0] SDone  = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == SIdle);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      SIdle: begin
        if (in_valid && in_op == OpCompute) begin
          cmd.capture = 1'b1;
          state_next = SPrepY;
        end
      end
      SPrepY: begin
        cmd.div_load = 1'b1;
        state_next = sts.bad ? SDone : SDivY;
      end
      SDivY: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = SMulY;
      end
      SMulY: begin
        cmd.set_y = 1'b1;
        state_next = SPrepX;
      end
      SPrepX: begin
        cmd.div_load = 1'b1;
        cmd.sel_x = 1'b1;
        state_next = SDivX;
      end
      SDivX: begin
        cmd.div_step = 1'b1;
        cmd.sel_x = 1'b1;
        if (sts.div_last) state_next = SMulX;
      end
      SMulX: begin
        cmd.set_x = 1'b1;
        cmd.sel_x = 1'b1;
        state_next = SRead;
      end
      SRead: begin
        cmd.rd = 1'b1;
        state_next = SMac;
      end
      SMac: begin
        cmd.mac = 1'b1;
        state_next = sts.nb_last ? SDone : SRead;
      end
      SDone: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next = SIdle;
        end
      end
      default: state_next = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SIdle;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: hw/rtl/cirsz_dp.sv
// datapath: config registers, pixel store, shared divider, weights and accumulator
module cirsz_dp #(
  parameter int MAX_HEIGHT   = cirsz_pkg::DefMaxHeight,
  parameter int MAX_WIDTH    = cirsz_pkg::DefMaxWidth,
  parameter int MAX_CHANNELS = cirsz_pkg::DefMaxChannels,
  parameter int PIXEL_BITS   = cirsz_pkg::DefPixelBits
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic [2:0]      cfg_index,
  input  logic [10:0]     cfg_data,
  input  logic            in_fire,
  input  logic            in_op,
  input  logic [9:0]      in_row,
  input  logic [9:0]      in_col,
  input  logic [1:0]      in_channel,
  input  logic [15:0]     in_pixel,
  input  cirsz_pkg::cmd_t cmd,
  output cirsz_pkg::sts_t sts,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [9:0]      out_row,
  output logic [9:0]      out_col,
  output logic [1:0]      out_channel,
  output logic [15:0]     out_pixel,
  output logic            out_bad
);
  import cirsz_pkg::*;

  localparam int Depth = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int AW    = $clog2(Depth);
  localparam int NumW  = 24;
  localparam int AccW  = PIXEL_BITS + 33;

  // configuration
  logic        mode;
  logic [7:0]  src_height;
  logic [7:0]  src_width;
  logic [5:0]  crop_begin;
  logic [5:0]  crop_end;
  logic [10:0] dst_height;
  logic [10:0] dst_width;
  logic [2:0]  chan_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      src_height <= 8'd128;
      src_width  <= 8'd128;
      crop_begin <= 6'd0;
      crop_end   <= 6'd0;
      dst_height <= 11'd128;
      dst_width  <= 11'd128;
      chan_count <= 3'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        RegMode:      mode       <= cfg_data[0];
        RegSrcHeight: src_height <= cfg_data[7:0];
        RegSrcWidth:  src_width  <= cfg_data[7:0];
        RegCropBegin: crop_begin <= cfg_data[5:0];
        RegCropEnd:   crop_end   <= cfg_data[5:0];
        RegDstHeight: dst_height <= cfg_data;
        RegDstWidth:  dst_width  <= cfg_data;
        RegChanCount: chan_count <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // pixel store
  logic [PIXEL_BITS-1:0] mem [Depth];
  logic [PIXEL_BITS-1:0] rdata;
  logic [31:0]           ld_addr;
  logic                  ld_ok;
  logic [31:0]           rd_addr;

  assign ld_addr = (32'(in_channel) * 32'(MAX_HEIGHT) + 32'(in_row)) * 32'(MAX_WIDTH)
                   + 32'(in_col);
  assign ld_ok = (32'(in_channel) < 32'(MAX_CHANNELS)) && (32'(in_row) < 32'(MAX_HEIGHT))
                 && (32'(in_col) < 32'(MAX_WIDTH));

  // captured request
  logic [9:0] req_row;
  logic [9:0] req_col;
  logic [1:0] req_ch;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_row <= in_row;
      req_col <= in_col;
      req_ch  <= in_channel;
    end
  end

  // cropped sizes and request check
  logic [7:0] hs;
  logic [7:0] ws;
  logic [6:0] crop;
  logic [7:0] size_h;
  logic [7:0] size_w;
  logic       bad;

  assign hs = ({5'd0, src_height} > 13'(MAX_HEIGHT)) ? 8'(MAX_HEIGHT) : src_height;
  assign ws = ({5'd0, src_width} > 13'(MAX_WIDTH)) ? 8'(MAX_WIDTH) : src_width;
  assign crop = 7'(crop_begin) + 7'(crop_end);
  assign size_h = hs - 8'(crop);
  assign size_w = ws - 8'(crop);
  assign bad = (8'(crop) >= hs) || (8'(crop) >= ws) || (11'(req_row) >= dst_height)
               || (11'(req_col) >= dst_width) || (3'(req_ch) >= chan_count)
               || (7'(req_ch) >= 7'(MAX_CHANNELS));

  // shared restoring divider, one quotient bit per cycle
  logic [NumW-1:0] div_num;
  logic [10:0]     div_den;
  logic [11:0]     div_rem;
  logic [NumW-1:0] div_q;
  logic [4:0]      div_cnt;
  logic [NumW-1:0] num_sel;
  logic [10:0]     den_sel;
  logic [9:0]      coord_sel;
  logic [7:0]      size_sel;
  logic [10:0]     dim_sel;
  logic [11:0]     rem_sh;
  logic            rem_ge;

  assign coord_sel = cmd.sel_x ? req_col : req_row;
  assign size_sel  = cmd.sel_x ? size_w : size_h;
  assign dim_sel   = cmd.sel_x ? dst_width : dst_height;
  assign num_sel   = mode ? {size_sel - 8'd1, 16'd0} : NumW'(coord_sel) * NumW'(size_sel);
  assign den_sel   = mode ? dim_sel - 11'd1 : dim_sel;
  assign rem_sh    = {div_rem[10:0], div_num[NumW-1]};
  assign rem_ge    = rem_sh >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      div_num <= num_sel;
      div_den <= den_sel;
      div_rem <= '0;
      div_q   <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_num <= {div_num[NumW-2:0], 1'b0};
      div_rem <= rem_ge ? rem_sh - {1'b0, div_den} : rem_sh;
      div_q   <= {div_q[NumW-2:0], rem_ge};
      div_cnt <= div_cnt + 5'd1;
    end
  end

  // source position
  logic [NumW-1:0] ratio;
  logic [33:0]     pos;
  logic [7:0]      y0;
  logic [7:0]      x0;
  logic [15:0]     wy1;
  logic [15:0]     wx1;

  assign ratio = (dim_sel <= 11'd1) ? '0 : div_q;
  assign pos   = 34'(ratio) * 34'(coord_sel);

  always_ff @(posedge clk) begin
    if (cmd.set_y) begin
      y0  <= mode ? pos[23:16] : div_q[7:0];
      wy1 <= mode ? pos[15:0] : 16'd0;
    end
    if (cmd.set_x) begin
      x0  <= mode ? pos[23:16] : div_q[7:0];
      wx1 <= mode ? pos[15:0] : 16'd0;
    end
  end

  // neighbour walk
  logic [1:0]  nb;
  logic        dy;
  logic        dx;
  logic [8:0]  nb_r;
  logic [8:0]  nb_c;
  logic [16:0] wy;
  logic [16:0] wx;
  logic [32:0] wprod;

  assign dy   = (9'(y0) + 9'd1) < 9'(size_h);
  assign dx   = (9'(x0) + 9'd1) < 9'(size_w);
  assign nb_r = 9'(crop_begin) + 9'(y0) + 9'(nb[1] & dy);
  assign nb_c = 9'(crop_begin) + 9'(x0) + 9'(nb[0] & dx);
  assign wy   = nb[1] ? 17'(wy1) : 17'h10000 - 17'(wy1);
  assign wx   = nb[0] ? 17'(wx1) : 17'h10000 - 17'(wx1);
  assign rd_addr = (32'(req_ch) * 32'(MAX_HEIGHT) + 32'(nb_r)) * 32'(MAX_WIDTH) + 32'(nb_c);

  always_ff @(posedge clk) begin
    if (in_fire && in_op == OpLoad && ld_ok) begin
      mem[AW'(ld_addr)] <= PIXEL_BITS'(in_pixel);
    end
    if (cmd.rd) begin
      rdata <= mem[AW'(rd_addr)];
      wprod <= 33'(wy) * 33'(wx);
    end
  end

  // accumulator
  logic [AccW-1:0] acc;
  logic [AccW-1:0] rounded;

  always_ff @(posedge clk) begin
    if (rst || cmd.set_x) begin
      nb  <= 2'd0;
      acc <= '0;
    end else if (cmd.mac) begin
      nb  <= nb + 2'd1;
      acc <= acc + AccW'(wprod) * AccW'(rdata);
    end
  end

  assign rounded = (acc + (AccW'(1) << 31)) >> 32;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_row     <= req_row;
      out_col     <= req_col;
      out_channel <= req_ch;
      out_pixel   <= bad ? 16'd0 : rounded[15:0];
      out_bad     <= bad;
    end
  end

  assign sts.div_last = (div_cnt == 5'(NumW - 1));
  assign sts.nb_last  = (nb == 2'd3);
  assign sts.bad      = bad;
  assign sts.out_free = !out_valid || out_ready;

endmodule
